/* rtl/core/decision_tree_packet_classifier_defines.svh */
// Assertion macros used by the checker.
`ifndef DECISION_TREE_PACKET_CLASSIFIER_DEFINES_SVH
`define DECISION_TREE_PACKET_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTPC_ASSERT_IMPLY(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("dtpc assertion failed");

// Next-cycle implication, disabled during reset.
`define DTPC_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("dtpc assertion failed");

// Next-cycle implication, checked through reset too.
`define DTPC_ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("dtpc assertion failed");

`endif

/* rtl/core/dtpc_pkg.sv */
// ----------------------------------------------------------------------------
// dtpc_pkg
// Types, codes and helpers of the decision-tree packet classifier.
// ----------------------------------------------------------------------------
package dtpc_pkg;

    localparam int KEY_FIELDS = 5;
    localparam int KEY_W      = 32;

    typedef enum logic [1:0] {
        OP_WR_NODE     = 2'd0,
        OP_WR_RANGE    = 2'd1,
        OP_WR_PRIORITY = 2'd2,
        OP_CLASSIFY    = 2'd3
    } dtpc_op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  index;
        logic        is_leaf;
        logic [2:0]  dim;
        logic [9:0]  left_or_first;
        logic [10:0] right_or_count;
        logic [15:0] priority_req;
        logic [31:0] key0;
        logic [31:0] key1;
        logic [31:0] key2;
        logic [31:0] key3;
        logic [31:0] key4;
    } dtpc_in_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] best_priority;
        logic        depth_exceeded;
    } dtpc_out_t;

    // Node store entry, 57 bits.
    typedef struct packed {
        logic        leaf;
        logic [2:0]  dim;
        logic [31:0] split;
        logic [9:0]  left_or_first;
        logic [10:0] right_or_count;
    } dtpc_node_t;

    // Rule range entry of one dimension, 64 bits.
    typedef struct packed {
        logic [31:0] high;
        logic [31:0] low;
    } dtpc_range_t;

    typedef logic [KEY_FIELDS-1:0][KEY_W-1:0] dtpc_keys_t;

    // Controller -> datapath.
    typedef struct packed {
        logic ready;
        logic node_rd;
        logic walk_step;
        logic scan_init;
        logic scan_step;
        logic set_exceeded;
        logic out_load;
    } dtpc_cmd_t;

    // Datapath -> controller.
    typedef struct packed {
        logic classify_req;   // classify request offered on the input
        logic node_leaf;
        logic depth_max;
        logic next_oob;
        logic scan_done;
        logic pend;
        logic out_free;
    } dtpc_status_t;

    // Key of a dimension; missing dimensions read zero.
    function automatic logic [KEY_W-1:0] key_of(dtpc_keys_t keys, logic [2:0] d,
                                                 int dims);
        logic [KEY_W-1:0] k;
        k = '0;
        if (int'(d) < KEY_FIELDS && int'(d) < dims) begin
            k = keys[d];
        end
        return k;
    endfunction

endpackage

/* rtl/core/dtpc_ram.sv */
// ----------------------------------------------------------------------------
// dtpc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dtpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/dtpc_ctrl.sv */
// ----------------------------------------------------------------------------
// dtpc_ctrl
// Sequencer: tree walk, leaf rule scan, result hand-off.
// ----------------------------------------------------------------------------
module dtpc_ctrl
    import dtpc_pkg::*;
(
    input  logic         clk,
    input  logic         rstn,
    input  dtpc_status_t st,
    output dtpc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_NODE_RD   = 5'b00010,
        S_NODE_EVAL = 5'b00100,
        S_SCAN      = 5'b01000,
        S_FIN       = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.ready = 1'b1;
                // ready is high here, so an offered classify is taken now
                if (st.classify_req) begin
                    state_next = S_NODE_RD;
                end
            end
            S_NODE_RD: begin
                cmd.node_rd = 1'b1;
                state_next  = S_NODE_EVAL;
            end
            S_NODE_EVAL: begin
                if (st.node_leaf) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end else if (st.depth_max) begin
                    cmd.set_exceeded = 1'b1;
                    state_next       = S_FIN;
                end else if (st.next_oob) begin
                    state_next = S_FIN;      // lost walk: all zero
                end else begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_NODE_RD;
                end
            end
            S_SCAN: begin
                cmd.scan_step = !st.scan_done;
                if (st.scan_done && !st.pend) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/dtpc_datapath.sv */
// ----------------------------------------------------------------------------
// dtpc_datapath
// Stores, walk registers, rule match logic and result register.
// ----------------------------------------------------------------------------
module dtpc_datapath
    import dtpc_pkg::*;
#(
    parameter int NODE_SLOTS = 1024,
    parameter int RULE_SLOTS = 1024,
    parameter int DIMENSIONS = 5,
    parameter int MAX_DEPTH  = 32
) (
    input  logic         clk,
    input  logic         rstn,
    input  dtpc_cmd_t    cmd,
    output dtpc_status_t st,
    input  logic         s_valid,
    input  dtpc_in_t     s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output dtpc_out_t    m_data
);

    localparam int NA = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int RA = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic accept;
    assign accept = s_valid && cmd.ready;

    // ---- request decode / store writes
    dtpc_keys_t in_keys;
    assign in_keys = {s_data.key4, s_data.key3, s_data.key2, s_data.key1, s_data.key0};

    logic node_we, prio_we, range_ok;
    assign node_we  = accept && (s_data.op == OP_WR_NODE) &&
                      (32'(s_data.index) < NODE_SLOTS);
    assign range_ok = accept && (s_data.op == OP_WR_RANGE) &&
                      (32'(s_data.index) < RULE_SLOTS) && (32'(s_data.dim) < DIMENSIONS);
    assign prio_we  = accept && (s_data.op == OP_WR_PRIORITY) &&
                      (32'(s_data.index) < RULE_SLOTS);

    dtpc_node_t node_wdata, node_q;
    assign node_wdata = '{leaf: s_data.is_leaf, dim: s_data.dim, split: s_data.key0,
                          left_or_first: s_data.left_or_first,
                          right_or_count: s_data.right_or_count};

    // ---- walk registers
    dtpc_keys_t  keys_reg;
    logic [NA-1:0] cur_reg;
    logic [DW-1:0] depth_reg;
    logic [9:0]  first_reg;
    logic [10:0] count_reg;
    logic [10:0] i_reg;
    logic        pend_reg;
    logic        matched_reg;
    logic [15:0] best_reg;
    logic        exceeded_reg;

    logic        go_left;
    logic [10:0] next_idx;
    assign go_left  = key_of(keys_reg, node_q.dim, DIMENSIONS) <= node_q.split;
    assign next_idx = go_left ? {1'b0, node_q.left_or_first} : node_q.right_or_count;

    dtpc_ram #(.WIDTH($bits(dtpc_node_t)), .DEPTH(NODE_SLOTS)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (NA'(s_data.index)),
        .wdata (node_wdata),
        .re    (cmd.node_rd),
        .raddr (cur_reg),
        .rdata (node_q)
    );

    // ---- rule scan
    logic [11:0] slot;
    logic        slot_ok;
    assign slot    = 12'(first_reg) + 12'(i_reg);
    assign slot_ok = 32'(slot) < RULE_SLOTS;

    logic [15:0] prio_q;
    dtpc_ram #(.WIDTH(16), .DEPTH(RULE_SLOTS)) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (RA'(s_data.index)),
        .wdata (s_data.priority_req),
        .re    (cmd.scan_step),
        .raddr (RA'(slot)),
        .rdata (prio_q)
    );

    logic [DIMENSIONS-1:0] dim_ok;
    for (genvar d = 0; d < DIMENSIONS; d++) begin : g_dim
        dtpc_range_t   range_q;
        logic [KEY_W-1:0] kd;
        dtpc_ram #(.WIDTH($bits(dtpc_range_t)), .DEPTH(RULE_SLOTS)) u_range_ram (
            .clk   (clk),
            .we    (range_ok && (32'(s_data.dim) == d)),
            .waddr (RA'(s_data.index)),
            .wdata ({s_data.key1, s_data.key0}),
            .re    (cmd.scan_step),
            .raddr (RA'(slot)),
            .rdata (range_q)
        );
        if (d < KEY_FIELDS) begin : g_key
            assign kd = keys_reg[d];
        end else begin : g_nokey
            assign kd = '0;
        end
        assign dim_ok[d] = (range_q.low <= kd) && (range_q.high >= kd);
    end

    logic hit;
    assign hit = pend_reg && (&dim_ok) && (!matched_reg || (prio_q > best_reg));

    // ---- result register
    logic      m_valid_reg;
    dtpc_out_t m_data_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.scan_step && slot_ok;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept && (s_data.op == OP_CLASSIFY)) begin
            keys_reg     <= in_keys;
            cur_reg      <= '0;
            depth_reg    <= '0;
            matched_reg  <= 1'b0;
            best_reg     <= '0;
            exceeded_reg <= 1'b0;
        end
        if (cmd.walk_step) begin
            cur_reg   <= NA'(next_idx);
            depth_reg <= depth_reg + 1'b1;
        end
        if (cmd.set_exceeded) begin
            exceeded_reg <= 1'b1;
        end
        if (cmd.scan_init) begin
            first_reg <= node_q.left_or_first;
            count_reg <= node_q.right_or_count;
            i_reg     <= '0;
        end
        if (cmd.scan_step) begin
            i_reg <= i_reg + 1'b1;
        end
        if (hit) begin
            matched_reg <= 1'b1;
            best_reg    <= prio_q;
        end
        if (cmd.out_load) begin
            m_data_reg.matched        <= matched_reg;
            m_data_reg.best_priority  <= matched_reg ? best_reg : 16'd0;
            m_data_reg.depth_exceeded <= exceeded_reg;
        end
    end

    assign st.classify_req = s_valid && (s_data.op == OP_CLASSIFY);
    assign st.node_leaf    = node_q.leaf;
    assign st.depth_max    = (depth_reg == DW'(MAX_DEPTH));
    assign st.next_oob     = (32'(next_idx) >= NODE_SLOTS);
    assign st.scan_done    = (i_reg >= count_reg);
    assign st.pend         = pend_reg;
    assign st.out_free     = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/core/decision_tree_packet_classifier.sv */
// ----------------------------------------------------------------------------
// decision_tree_packet_classifier
// Decision-tree packet classification lookup engine with loadable stores.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  dtpc_in_t  (store writes, classify)
//  m_       out  m_valid / m_ready  dtpc_out_t (one result per classify)
//
//  A classify request is served by the node store read port (read, then
//  decide, per split level walked) and one rule read per cycle during
//  the leaf rule scan.
//  Reset (aresetn low, synchronous) clears control only; stores keep data.
//  The result register holds a result under m_ready low; a new request
//  is taken meanwhile, and a finishing classify waits for the register.
// ----------------------------------------------------------------------------
module decision_tree_packet_classifier
    import dtpc_pkg::*;
#(
    parameter int NODE_SLOTS = 1024,
    parameter int RULE_SLOTS = 1024,
    parameter int DIMENSIONS = 5,
    parameter int MAX_DEPTH  = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dtpc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output dtpc_out_t m_data
);

    // Command and status between sequencer and datapath.
    dtpc_cmd_t    cmd;
    dtpc_status_t st;

    dtpc_ctrl u_ctrl (
        .clk  (aclk),
        .rstn (aresetn),
        .st   (st),
        .cmd  (cmd)
    );

    // Node store, per-dimension range banks, priority store.
    dtpc_datapath #(
        .NODE_SLOTS (NODE_SLOTS),
        .RULE_SLOTS (RULE_SLOTS),
        .DIMENSIONS (DIMENSIONS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_dp (
        .clk     (aclk),
        .rstn    (aresetn),
        .cmd     (cmd),
        .st      (st),
        .s_valid (s_valid),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Requests are taken only while the sequencer is idle.
    assign s_ready = cmd.ready;

endmodule

/* rtl/core/dtpc_checker.sv */
// ----------------------------------------------------------------------------
// dtpc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "decision_tree_packet_classifier_defines.svh"

module dtpc_checker
    import dtpc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input dtpc_out_t m_data
);

    `DTPC_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `DTPC_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `DTPC_ASSERT_IMPLY(a_nomatch_zero, aclk, aresetn, m_valid && !m_data.matched, m_data.best_priority == 16'd0)
    `DTPC_ASSERT_IMPLY(a_exceed_nomatch, aclk, aresetn, m_valid && m_data.depth_exceeded, !m_data.matched)
    `DTPC_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind decision_tree_packet_classifier dtpc_checker u_dtpc_checker (.*);

/* dv/decision_tree_packet_classifier_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decision_tree_packet_classifier_checker
// Watches both channels, keeps its own copy of the node and rule stores,
// walks the tree for each classify request and compares the results.
// ----------------------------------------------------------------------------
module decision_tree_packet_classifier_checker
    import dtpc_pkg::*;
#(
    parameter int NODE_SLOTS = 1024,
    parameter int RULE_SLOTS = 1024,
    parameter int DIMENSIONS = 5,
    parameter int MAX_DEPTH  = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  dtpc_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  dtpc_out_t m_data,
    output int        fail_count,
    output int        pending_count
);

    dtpc_node_t  nodes [NODE_SLOTS];
    dtpc_range_t ranges[RULE_SLOTS * DIMENSIONS];
    logic [15:0] prios [RULE_SLOTS];
    dtpc_out_t   verdicts[$];
    int          fails = 0;

    assign fail_count    = fails;
    assign pending_count = verdicts.size();

    function automatic logic [31:0] key_at(dtpc_in_t r, int d);
        case (d)
            0: return r.key0;
            1: return r.key1;
            2: return r.key2;
            3: return r.key3;
            4: return r.key4;
            default: return '0;
        endcase
    endfunction

    function automatic dtpc_out_t classify_verdict(dtpc_in_t r);
        dtpc_out_t  v;
        dtpc_node_t n;
        int         cur, depth, nxt, slot;
        logic [31:0] k;
        bit         ok, stop;
        v = '0;
        cur = 0;
        depth = 0;
        stop = 0;
        while (!nodes[cur].leaf && !stop) begin
            n = nodes[cur];
            if (depth >= MAX_DEPTH) begin
                v.depth_exceeded = 1'b1;
                return v;
            end
            depth++;
            k = (n.dim < DIMENSIONS) ? key_at(r, n.dim) : '0;
            nxt = (k <= n.split) ? n.left_or_first : n.right_or_count;
            if (nxt >= NODE_SLOTS) return v;
            cur = nxt;
        end
        for (int i = 0; i < nodes[cur].right_or_count; i++) begin
            slot = nodes[cur].left_or_first + i;
            if (slot >= RULE_SLOTS) continue;
            if (v.matched && prios[slot] <= v.best_priority) continue;
            ok = 1;
            for (int d = 0; d < DIMENSIONS; d++) begin
                k = key_at(r, d);
                if (!(ranges[slot*DIMENSIONS+d].low <= k &&
                      ranges[slot*DIMENSIONS+d].high >= k)) ok = 0;
            end
            if (ok) begin
                v.matched = 1'b1;
                v.best_priority = prios[slot];
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        dtpc_out_t want;
        if (aresetn && s_valid && s_ready) begin
            case (dtpc_op_t'(s_data.op))
                OP_WR_NODE: if (s_data.index < NODE_SLOTS)
                    nodes[s_data.index] = '{s_data.is_leaf, s_data.dim, s_data.key0,
                                            s_data.left_or_first, s_data.right_or_count};
                OP_WR_RANGE: if (s_data.index < RULE_SLOTS && s_data.dim < DIMENSIONS)
                    ranges[s_data.index*DIMENSIONS+s_data.dim] = '{s_data.key1, s_data.key0};
                OP_WR_PRIORITY: if (s_data.index < RULE_SLOTS)
                    prios[s_data.index] = s_data.priority_req;
                OP_CLASSIFY: verdicts = {verdicts, classify_verdict(s_data)};
            endcase
        end
        if (aresetn && m_valid && m_ready) begin
            if (verdicts.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result %p", m_data);
            end else begin
                want = verdicts.pop_front();
                if (want !== m_data) begin
                    fails++;
                    if (fails <= 10)
                        $display("result mismatch: expected %p got %p", want, m_data);
                end
            end
        end
    end

endmodule

/* dv/decision_tree_packet_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decision_tree_packet_classifier_tb
// Loads random trees and rule lists, fires classify requests whose keys are
// drawn near split points and rule bounds, and checks each lookup result.
// ----------------------------------------------------------------------------
module decision_tree_packet_classifier_tb;
    import dtpc_pkg::*;

    localparam int LIMIT    = 2_000_000;
    localparam int RULE_WIN = 40;     // rule slots 0..RULE_WIN-1 plus 1016..1023

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    dtpc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    dtpc_out_t m_data;
    int        fail_count, pending_count;
    int        cycles = 0;
    bit        calm = 0;        // no idling on either side while set

    // Shadow of what was written, used only to pick keys that hit things.
    logic [31:0] splits[$];
    logic [31:0] bounds[$];
    int          node_top;      // nodes 0..node_top-1 are written

    always #2 aclk = ~aclk;

    decision_tree_packet_classifier dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    decision_tree_packet_classifier_checker chk (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Result side stalls about 12% of cycles except during calm stretches.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 12);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("decision_tree_packet_classifier_tb: errors");
            $finish;
        end
    end

    // One request: optional idle gap, then hold valid until taken.
    // Valid stays up across back-to-back requests.
    task automatic send(dtpc_in_t r);
        while (!calm && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wr_node(int idx, bit leaf, int d, logic [31:0] sp, int lf, int rc);
        dtpc_in_t r;
        r = '0;
        r.op = OP_WR_NODE; r.index = 10'(idx); r.is_leaf = leaf; r.dim = 3'(d);
        r.key0 = sp; r.left_or_first = 10'(lf); r.right_or_count = 11'(rc);
        r.priority_req = 16'($urandom); r.key1 = $urandom;
        send(r);
        if (!leaf) splits = {splits, sp};
    endtask

    // Full rule: all five ranges plus priority, with some junk-dim writes.
    task automatic wr_rule(int slot, bit wide);
        dtpc_in_t r;
        logic [31:0] a, b;
        for (int d = 0; d < 5; d++) begin
            a = $urandom; b = $urandom;
            if (wide || $urandom_range(3) == 0) begin a = 0; b = '1; end
            else if (a > b) begin a = b; b = a ^ b ^ b; a = b; a = $urandom_range(b); end
            r = '0; r.op = OP_WR_RANGE; r.index = 10'(slot); r.dim = 3'(d);
            r.key0 = a; r.key1 = b; send(r);
            bounds = {bounds, a};
            bounds = {bounds, b};
        end
        if ($urandom_range(7) == 0) begin
            r = '0; r.op = OP_WR_RANGE; r.index = 10'(slot);
            r.dim = 3'($urandom_range(7, 5)); r.key0 = $urandom; r.key1 = $urandom;
            send(r);
        end
        r = '0; r.op = OP_WR_PRIORITY; r.index = 10'(slot);
        r.priority_req = 16'($urandom);
        send(r);
    endtask

    function automatic logic [31:0] pick_key();
        int c;
        logic [31:0] v;
        c = $urandom_range(9);
        if (c < 4 && splits.size() > 0) v = splits[$urandom_range(splits.size()-1)];
        else if (c < 8 && bounds.size() > 0) v = bounds[$urandom_range(bounds.size()-1)];
        else if (c == 8) return $urandom_range(1) ? '0 : '1;
        else return $urandom;
        return v + 32'($urandom_range(2)) - 32'd1;
    endfunction

    task automatic classify();
        dtpc_in_t r;
        r = '0;
        r.op = OP_CLASSIFY;
        r.index = 10'($urandom); r.is_leaf = 1'($urandom); r.dim = 3'($urandom);
        r.left_or_first = 10'($urandom); r.right_or_count = 11'($urandom);
        r.priority_req = 16'($urandom);
        r.key0 = pick_key(); r.key1 = pick_key(); r.key2 = pick_key();
        r.key3 = pick_key(); r.key4 = pick_key();
        send(r);
    endtask

    // Leaf at node idx with a rule list inside slots already written.
    task automatic leaf_at(int idx);
        int first, cnt;
        first = $urandom_range(RULE_WIN - 8);
        cnt = $urandom_range(8);
        if ($urandom_range(15) == 0) begin first = 1020; cnt = 1024; end  // runs off store
        wr_node(idx, 1, $urandom, $urandom, first, cnt);
    endtask

    // Random tree: nodes 0..n-1 heap-shaped, children beyond n become leaves,
    // occasionally a child points outside the store.
    task automatic build_tree(int n);
        int lc, rc;
        splits.delete();
        for (int i = 0; i < n; i++) begin
            lc = 2*i + 1; rc = 2*i + 2;
            if ($urandom_range(19) == 0) rc = 1024;
            wr_node(i, 0, $urandom_range(7), $urandom, lc, rc);
        end
        for (int i = n; i <= 2*n; i++) leaf_at(i);
        node_top = 2*n + 1;
    endtask

    initial begin
        dtpc_in_t r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the rule slots that leaves point at, so no scan reads an
        // unwritten entry.
        calm = 1;
        for (int s = 0; s < RULE_WIN; s++) wr_rule(s, 0);
        for (int s = 1016; s < 1024; s++) wr_rule(s, s == 1023);
        calm = 0;

        // Directed: single leaf root, count running off the store, extremes.
        wr_node(0, 1, 7, '1, 1023, 1);
        r = '0; r.op = OP_CLASSIFY; r.key0 = '1; r.key4 = '1; send(r);
        r = '0; r.op = OP_CLASSIFY; send(r);
        wr_node(0, 1, 0, 0, 1016, 1024);
        classify();
        wr_node(0, 1, 0, 0, 1000, 0);
        classify();
        // Root's right child out of the store, left child at the last node slot.
        wr_node(0, 0, 4, 32'h8000_0000, 1023, 1024);
        r = '0; r.op = OP_CLASSIFY; r.key4 = '1; send(r);
        r = '0; r.op = OP_CLASSIFY; send(r);
        // Self loop: depth limit.
        wr_node(0, 0, 5, 0, 0, 0);
        classify();
        // Missing dimensions and an ignored range write beyond the dims.
        wr_node(0, 0, 6, 0, 1, 2);
        wr_node(1, 1, 0, 0, 10, 8);
        wr_node(2, 1, 0, 0, 20, 8);
        classify();
        r = '0; r.op = OP_WR_RANGE; r.index = 10'd1023; r.dim = 3'd7; r.key0 = '1; send(r);
        // Chain of exactly MAX_DEPTH splits, then one more.
        for (int i = 0; i < 32; i++) wr_node(i, 0, 0, '1, i + 1, 1024);
        wr_node(32, 1, 0, 0, 30, 4);
        classify();
        wr_node(32, 0, 0, '1, 33, 1024);
        wr_node(33, 1, 0, 0, 30, 4);
        classify();

        // Random phases: trees of varied size, many classifies each.
        for (int ph = 0; ph < 16 && cycles < LIMIT / 2; ph++) begin
            build_tree($urandom_range(1, 12));
            calm = (ph % 4 == 2);
            for (int j = 0; j < 40; j++) begin
                if ($urandom_range(19) == 0) leaf_at($urandom_range(node_top - 1));
                else if ($urandom_range(29) == 0) wr_rule($urandom_range(RULE_WIN - 1), 0);
                else classify();
            end
            calm = 0;
        end
        s_valid <= 1'b0;

        while (pending_count > 0 && cycles < LIMIT) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("decision_tree_packet_classifier_tb: clean");
        else
            $display("decision_tree_packet_classifier_tb: errors");
        $finish;
    end

endmodule
